### rtl/core/e2c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_pkg: shared constants and helpers for the epoch-to-calendar converter
// Field widths, reciprocal constants for the divide-by-constant steps and the
// cumulative month-start tables.
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam int SecsW  = 32;
  localparam int DaysW  = 17;   // days since 1900-01-01, up to 75277
  localparam int DaysEW = 16;   // days since 1970-01-01, up to 49710
  localparam int SodW   = 17;   // seconds of day, below 86400
  localparam int YOffW  = 8;    // year offset from 1900, up to 206
  localparam int DoyW   = 9;    // day of year, 0 to 365
  localparam int RemW   = 12;   // seconds of hour, below 3600

  localparam int YearW  = 12;
  localparam int MonW   = 4;
  localparam int DayW   = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;

  localparam int InDataW  = 32;
  localparam int OutDataW = 40;

  // secs / 86400 = (secs >> 7) / 675, exact as (x * DayRecip) >> 35
  localparam logic [25:0] DayRecip   = 26'd50903317;
  localparam int          DayShift   = 35;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [16:0] BiasDays   = 17'd25567;

  // days / 365, exact as (days * YearRecip) >> 26
  localparam logic [17:0] YearRecip  = 18'd183861;
  localparam int          YearShift  = 26;
  localparam logic [8:0]  DaysPerYr  = 9'd365;

  // (sod >> 4) / 225, exact as (x * HourRecip) >> 21
  localparam logic [13:0] HourRecip  = 14'd9321;
  localparam int          HourShift  = 21;
  localparam logic [11:0] SecsPerHr  = 12'd3600;

  // (rem >> 2) / 15, exact as (x * MinRecip) >> 14
  localparam logic [10:0] MinRecip   = 11'd1093;
  localparam int          MinShift   = 14;
  localparam logic [5:0]  SecsPerMin = 6'd60;

  localparam logic [YearW-1:0] BaseYear = 12'd1900;

  // First day (from 1900-01-01) of year offset y, for y >= 1
  function automatic logic [DaysW-1:0] year_start(input logic [YOffW-1:0] y);
    logic [YOffW-1:0] ym1;
    begin
      ym1 = y - YOffW'(1);
      year_start = DaysW'(y) * DaysW'(DaysPerYr) + DaysW'(ym1 >> 2);
    end
  endfunction

  // Day of year on which month index m (0 = January) starts
  function automatic logic [DoyW-1:0] cum_days(input logic leap, input logic [3:0] m);
    logic [DoyW-1:0] base;
    begin
      case (m)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      cum_days = (leap && m >= 4'd2) ? base + 9'd1 : base;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/core/e2c_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_split: split seconds into days and seconds of day
// Three stages: reciprocal multiply, day count times 86400, subtract.
// ----------------------------------------------------------------------------
module e2c_split
  import e2c_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [SecsW-1:0] secs,
  output logic      [DaysW-1:0] days,   // days since 1900-01-01
  output logic      [SodW-1:0]  sod
);

  logic [SecsW-1:0]  s1_secs_r;
  logic [50:0]       s1_prod_r;
  logic [SecsW-1:0]  s2_secs_r;
  logic [SecsW-1:0]  s2_dm_r;
  logic [DaysW-1:0]  s2_days_r;
  logic [DaysW-1:0]  s3_days_r;
  logic [SodW-1:0]   s3_sod_r;
  logic [DaysEW-1:0] days_e;
  logic [SecsW-1:0]  sod_full;

  assign days_e   = s1_prod_r[DayShift +: DaysEW];
  assign sod_full = s2_secs_r - s2_dm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_secs_r <= secs;
      s1_prod_r <= 51'(secs[SecsW-1:7]) * 51'(DayRecip);
      s2_secs_r <= s1_secs_r;
      s2_dm_r   <= SecsW'(days_e) * SecsW'(SecsPerDay);
      s2_days_r <= DaysW'(days_e) + BiasDays;
      s3_days_r <= s2_days_r;
      s3_sod_r  <= sod_full[SodW-1:0];
    end
  end

  assign days = s3_days_r;
  assign sod  = s3_sod_r;

endmodule
`default_nettype wire

### rtl/core/e2c_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_date: day count to year, month and day of month
// Four stages: year estimate, year starts, one-step correction, month lookup.
// ----------------------------------------------------------------------------
module e2c_date
  import e2c_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DaysW-1:0] days,
  output logic      [YearW-1:0] year,
  output logic      [MonW-1:0]  month,
  output logic      [DayW-1:0]  day
);

  logic [DaysW-1:0] d1_days_r;
  logic [34:0]      d1_prod_r;
  logic [DaysW-1:0] d2_days_r;
  logic [YOffW-1:0] d2_y0_r;
  logic [DaysW-1:0] d2_ys0_r;
  logic [DaysW-1:0] d2_ys1_r;
  logic [YOffW-1:0] d3_y_r;
  logic [DoyW-1:0]  d3_doy_r;
  logic [YearW-1:0] d4_year_r;
  logic [MonW-1:0]  d4_month_r;
  logic [DayW-1:0]  d4_day_r;

  logic [YOffW-1:0] y0;
  logic             late;
  logic [DaysW-1:0] doy_full;
  logic             leap;
  logic [3:0]       mon_idx;
  logic [DoyW-1:0]  day_raw;

  assign y0       = d1_prod_r[YearShift +: YOffW];
  // step back one year when the estimate starts after the target day
  assign late     = d2_days_r < d2_ys0_r;
  assign doy_full = d2_days_r - (late ? d2_ys1_r : d2_ys0_r);
  assign leap     = (d3_y_r[1:0] == 2'b00) && (d3_y_r != '0);

  always_comb begin
    mon_idx = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (d3_doy_r >= cum_days(leap, 4'(i))) mon_idx = 4'(i);
    end
  end

  assign day_raw = d3_doy_r - cum_days(leap, mon_idx) + 9'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1_days_r  <= days;
      d1_prod_r  <= 35'(days) * 35'(YearRecip);
      d2_days_r  <= d1_days_r;
      d2_y0_r    <= y0;
      d2_ys0_r   <= year_start(y0);
      d2_ys1_r   <= year_start(y0 - YOffW'(1));
      d3_y_r     <= late ? d2_y0_r - YOffW'(1) : d2_y0_r;
      d3_doy_r   <= doy_full[DoyW-1:0];
      d4_year_r  <= YearW'(d3_y_r) + BaseYear;
      d4_month_r <= mon_idx + 4'd1;
      d4_day_r   <= day_raw[DayW-1:0];
    end
  end

  assign year  = d4_year_r;
  assign month = d4_month_r;
  assign day   = d4_day_r;

endmodule
`default_nettype wire

### rtl/core/e2c_clock.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_clock: seconds of day to hour, minute and second
// Four stages: hour estimate, hour remainder, minute estimate, remainders.
// ----------------------------------------------------------------------------
module e2c_clock
  import e2c_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [SodW-1:0]  sod,
  output logic      [HourW-1:0] hour,
  output logic      [MinW-1:0]  minute,
  output logic      [SecW-1:0]  second
);

  logic [SodW-1:0]  c1_sod_r;
  logic [26:0]      c1_prod_r;
  logic [HourW-1:0] c2_hour_r;
  logic [RemW-1:0]  c2_rem_r;
  logic [HourW-1:0] c3_hour_r;
  logic [RemW-1:0]  c3_rem_r;
  logic [20:0]      c3_prod_r;
  logic [HourW-1:0] c4_hour_r;
  logic [MinW-1:0]  c4_min_r;
  logic [SecW-1:0]  c4_sec_r;

  logic [HourW-1:0] hr;
  logic [SodW-1:0]  rem_full;
  logic [MinW-1:0]  mn;
  logic [RemW-1:0]  sec_full;

  assign hr       = c1_prod_r[HourShift +: HourW];
  assign rem_full = c1_sod_r - SodW'(hr) * SodW'(SecsPerHr);
  assign mn       = c3_prod_r[MinShift +: MinW];
  assign sec_full = c3_rem_r - RemW'(mn) * RemW'(SecsPerMin);

  always_ff @(posedge clk) begin
    if (en) begin
      c1_sod_r  <= sod;
      c1_prod_r <= 27'(sod[SodW-1:4]) * 27'(HourRecip);
      c2_hour_r <= hr;
      c2_rem_r  <= rem_full[RemW-1:0];
      c3_hour_r <= c2_hour_r;
      c3_rem_r  <= c2_rem_r;
      c3_prod_r <= 21'(c2_rem_r[RemW-1:2]) * 21'(MinRecip);
      c4_hour_r <= c3_hour_r;
      c4_min_r  <= mn;
      c4_sec_r  <= sec_full[SecW-1:0];
    end
  end

  assign hour   = c4_hour_r;
  assign minute = c4_min_r;
  assign second = c4_sec_r;

endmodule
`default_nettype wire

### rtl/core/epoch_seconds_to_calendar_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top: epoch seconds to calendar date and time
// Usage:
//   Input stream (in_*): one word per timestamp, in_tdata = unsigned seconds
//   since 1970-01-01 00:00:00. Output stream (out_*): one word per input,
//   carrying year, month, day, hour, minute and second.
//   Leap years are offsets from 1900 that are multiples of four and nonzero,
//   so 2100 counts as leap; all ones maps to 2106-02-06 06:28:15.
//   A new word is taken every cycle while the output is not stalled; there
//   are seven register stages (3 split, then 4 parallel date and clock
//   stages), each holding at most one reciprocal multiply or constant
//   multiply-subtract.
//   Stall: all stages advance together when the output stage is empty or
//   taken; while out_tvalid is high and out_tready low, every stage holds
//   and in_tready drops, so nothing is lost or repeated. Empty stages still
//   advance only with the whole pipe.
//   Reset (rst_n low, synchronous) clears all stage valid bits; data
//   registers are not reset. There is no configuration.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top
  import e2c_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,   // [31:0] seconds
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
  // [31:26] minute, [37:32] second, [39:38] zero
  output logic      [OutDataW-1:0] out_tdata
);

  localparam int Stages = 7;

  logic [Stages-1:0] vld_r;
  logic              adv;
  logic [DaysW-1:0]  days;
  logic [SodW-1:0]   sod;
  logic [YearW-1:0]  year;
  logic [MonW-1:0]   month;
  logic [DayW-1:0]   day;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;

  // advance the whole pipe when the last word is gone or being taken
  assign adv       = !vld_r[Stages-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Stages-2:0], in_tvalid};
    end
  end

  // seconds -> days since 1900 and seconds of day (3 stages)
  e2c_split u_split (
    .clk  (clk),
    .en   (adv),
    .secs (in_tdata[SecsW-1:0]),
    .days (days),
    .sod  (sod)
  );

  // days -> year, month, day (4 stages)
  e2c_date u_date (
    .clk   (clk),
    .en    (adv),
    .days  (days),
    .year  (year),
    .month (month),
    .day   (day)
  );

  // seconds of day -> hour, minute, second (4 stages, aligned with date)
  e2c_clock u_clock (
    .clk    (clk),
    .en     (adv),
    .sod    (sod),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  assign out_tvalid = vld_r[Stages-1];
  assign out_tdata  = {2'b00, second, minute, hour, day, month, year};

endmodule
`default_nettype wire

### dv/tb_epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_top: stream test of the epoch-to-calendar block
// Drives timestamps into the input stream. Each accepted word is converted
// here to year, month, day, hour, minute and second, and the date word that
// comes out is checked field by field against the oldest pending conversion.
// Both sides idle at random, and a long output stall backs the pipe up.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_top;
  import e2c_pkg::*;

  localparam int PipeLatency    = 7;
  localparam int WatchdogCycles = 1000;
  localparam int RandomWords    = 700;
  localparam int LongHoldCycles = 100;

  // Date word as it leaves the block, most significant field first
  typedef struct packed {
    logic [1:0]      pad;
    logic [SecW-1:0]  second;
    logic [MinW-1:0]  minute;
    logic [HourW-1:0] hour;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } date_word_t;

  // Month starts within a common year
  localparam int unsigned MonthStart[12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic clk;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata  = '0;     // [31:0] seconds
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;         // year, month, day, hour, minute, second

  // Receiver ready is the random sink's ready, gated by the long hold
  logic rx_ready   = 1'b1;
  logic rx_hold_on = 1'b0;
  int   hold_left  = 0;
  assign out_tready = rx_ready && !rx_hold_on;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  date_word_t pending_dates[$];
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;

  epoch_seconds_to_calendar_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Leap rule of the block: offset from 1900 is a nonzero multiple of four
  function automatic bit leap_offset(input int unsigned yoff);
    return (yoff % 4 == 0) && (yoff != 0);
  endfunction

  function automatic int unsigned month_first_day(input bit leap, input int unsigned m);
    return MonthStart[m] + ((leap && m >= 2) ? 1 : 0);
  endfunction

  // Expected date word for a timestamp
  function automatic date_word_t to_calendar(input logic [31:0] secs);
    date_word_t  w;
    int unsigned days, sod, yoff, ystart, m;
    bit          leap;
    days = 25567 + secs / 86400;
    sod  = secs % 86400;
    yoff = days / 365;
    // step the year guess down until its first day is not past the target
    forever begin
      ystart = 365 * yoff + (yoff - 1) / 4;
      if (yoff <= 1 || days >= ystart) break;
      yoff--;
    end
    days -= ystart;
    leap = leap_offset(yoff);
    m = 11;
    while (m > 0 && days < month_first_day(leap, m)) m--;
    w.pad    = '0;
    w.year   = YearW'(yoff + 1900);
    w.month  = MonW'(m + 1);
    w.day    = DayW'(days - month_first_day(leap, m) + 1);
    w.hour   = HourW'(sod / 3600);
    w.minute = MinW'((sod % 3600) / 60);
    w.second = SecW'(sod % 60);
    return w;
  endfunction

  // Seconds count of a date under the block's leap rule (stimulus only)
  function automatic longint date_to_secs(input int yr, input int mo, input int d,
                                          input int h, input int mi, input int s);
    longint days;
    days = 0;
    for (int yy = 1970; yy < yr; yy++) days += leap_offset(yy - 1900) ? 366 : 365;
    days += month_first_day(leap_offset(yr - 1900), mo - 1) + d - 1;
    return days * 86400 + h * 3600 + mi * 60 + s;
  endfunction

  function automatic void report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Record accepted timestamps, check date words, and watch for a hang
  always @(posedge clk) begin : date_checker
    date_word_t want, got;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (in_tvalid && in_tready) pending_dates.push_back(to_calendar(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_dates.size() == 0) begin
          $display("%0t mismatch word: expected none actual %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = pending_dates.pop_front();
          report_field("year",   want.year,   got.year);
          report_field("month",  want.month,  got.month);
          report_field("day",    want.day,    got.day);
          report_field("hour",   want.hour,   got.hour);
          report_field("minute", want.minute, got.minute);
          report_field("second", want.second, got.second);
          report_field("pad",    want.pad,    got.pad);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogCycles) begin
        $display("timeout: no word moved for %0d cycles", WatchdogCycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Long receiver hold, counted down here so the sender keeps offering words
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rx_hold_on <= 1'b1;
      hold_left  <= hold_left - 1;
    end else begin
      rx_hold_on <= 1'b0;
    end
  end

  // Result sink: stall a random number of cycles before each date word
  initial begin : result_sink
    int stall;
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 7) : 0;
      repeat (stall) begin
        @(negedge clk);
        rx_ready <= 1'b0;
      end
      @(negedge clk);
      rx_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid && out_tready));
    end
  end

  // Offer one timestamp after a random gap; return at the accepting edge
  task automatic send_timestamp(input logic [31:0] secs);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_date(input int yr, input int mo, input int d,
                           input int h, input int mi, input int s);
    send_timestamp(32'(date_to_secs(yr, mo, d, h, mi, s)));
  endtask

  // Stop offering and wait until every pending date word has come back
  task automatic drain_pipe();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (PipeLatency + 3) @(posedge clk);
  endtask

  task automatic test_corner_values();
    send_timestamp(32'd0);
    send_timestamp(32'd1);
    send_timestamp(32'd59);
    send_timestamp(32'd60);
    send_timestamp(32'd3599);
    send_timestamp(32'd3600);
    send_timestamp(32'd86399);
    send_timestamp(32'd86400);
    send_timestamp(32'h7FFF_FFFF);
    send_timestamp(32'h8000_0000);
    send_timestamp(32'hFFFF_FFFE);
    // all ones lands on 2106-02-06 06:28:15 with 2100 as a leap year
    send_timestamp(32'hFFFF_FFFF);
    drain_pipe();
  endtask

  task automatic test_leap_rule();
    send_date(1972, 2, 28, 23, 59, 59);
    send_date(1972, 2, 29, 0, 0, 0);
    send_date(1972, 12, 31, 23, 59, 59);
    send_date(2000, 2, 29, 12, 34, 56);
    send_date(2000, 3, 1, 0, 0, 0);
    send_date(2099, 12, 31, 23, 59, 59);
    // 2100 keeps a February 29 here, and every later date shifts by a day
    send_date(2100, 2, 29, 0, 0, 0);
    send_date(2100, 3, 1, 0, 0, 0);
    send_date(2100, 12, 31, 23, 59, 59);
    send_date(2105, 12, 31, 23, 59, 59);
    drain_pipe();
  endtask

  // Hold the output long enough for the pipe to fill and drop in_tready
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    @(posedge clk);
    hold_left = LongHoldCycles;
    repeat (40) send_timestamp($urandom);
    drain_pipe();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_stream();
    int     pick, yr, mo, d, mlen, sod;
    longint secs;
    for (int n = 0; n < RandomWords; n++) begin
      // change idling habits every 50 words; the first stretch runs flat out
      if (n % 50 == 0) begin
        tx_idle_en = (n != 0) && ($urandom_range(0, 3) != 0);
        rx_idle_en = (n != 0) && ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_timestamp($urandom);
      end else begin
        yr   = $urandom_range(1970, 2105);
        mo   = $urandom_range(1, 12);
        mlen = (mo == 12) ? 31 :
               month_first_day(leap_offset(yr - 1900), mo) -
               month_first_day(leap_offset(yr - 1900), mo - 1);
        if (pick < 9) begin
          // land a few seconds around a month or day edge
          d    = $urandom_range(0, 1) ? mlen : 1;
          sod  = $urandom_range(0, 1) ? 86399 : 0;
          secs = date_to_secs(yr, mo, d, 0, 0, 0) + sod + $urandom_range(0, 4) - 2;
        end else begin
          d    = $urandom_range(1, mlen);
          secs = date_to_secs(yr, mo, d, 0, 0, 0) + $urandom_range(0, 86399);
        end
        if (secs < 0) secs = 0;
        send_timestamp(32'(secs));
      end
    end
    drain_pipe();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_corner_values();
    test_leap_rule();
    test_backpressure();
    test_random_stream();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/e2c_pkg.sv
rtl/core/e2c_split.sv
rtl/core/e2c_date.sv
rtl/core/e2c_clock.sv
rtl/core/epoch_seconds_to_calendar_top.sv
dv/tb_epoch_seconds_to_calendar_top.sv
